/* rtl/attribute_set_logic_unit_macros.svh */
// ---------------------------------------------------------------------------
// Attribute set logic unit assertion macros
// Shared concurrent assertion forms, clocked on clk_i, held off in reset.
// ---------------------------------------------------------------------------
`ifndef ATTRIBUTE_SET_LOGIC_UNIT_MACROS_SVH
`define ATTRIBUTE_SET_LOGIC_UNIT_MACROS_SVH

// same-cycle implication
`define ASL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/asl_pkg.sv */
// ---------------------------------------------------------------------------
// Attribute set logic unit package
// Word types, action codes and bit-set helper functions.
// ---------------------------------------------------------------------------
package asl_pkg;

  localparam int unsigned NUM_ATTRS = 64;
  localparam int unsigned SET_W     = 64;
  localparam int unsigned CNT_W     = $clog2(SET_W + 1);

  localparam logic [SET_W-1:0] ATTR_MASK =
    SET_W'((65'd1 << NUM_ATTRS) - 65'd1);

  typedef enum logic [3:0] {
    ACT_AND      = 4'd0,
    ACT_OR       = 4'd1,
    ACT_ANDNOT   = 4'd2,
    ACT_LESS     = 4'd3,
    ACT_GREATER  = 4'd4,
    ACT_SUPERSET = 4'd5,
    ACT_SUBSET   = 4'd6,
    ACT_JOIN     = 4'd7,
    ACT_EQUAL    = 4'd8
  } action_e;

  typedef struct packed {
    action_e          action;
    logic [SET_W-1:0] set_a;
    logic [SET_W-1:0] set_b;
  } in_word_t;

  typedef struct packed {
    logic [SET_W-1:0] result_set;
    logic             flag;
  } out_word_t;

  // set every bit at or above the lowest set bit
  function automatic logic [SET_W-1:0] prefix_or(input logic [SET_W-1:0] x);
    logic [SET_W-1:0] r;
    r = x;
    for (int s = 1; s < SET_W; s = s * 2) begin
      r = r | (r << s);
    end
    return r;
  endfunction

  function automatic logic at_most_one(input logic [SET_W-1:0] x);
    logic [SET_W-1:0] above;
    above = prefix_or(x) << 1;
    return ~|(x & above);
  endfunction

  // add pairwise in a balanced tree
  function automatic logic [CNT_W-1:0] popcount(input logic [SET_W-1:0] x);
    logic [CNT_W-1:0] lvl [SET_W];
    for (int i = 0; i < SET_W; i++) begin
      lvl[i] = CNT_W'(x[i]);
    end
    for (int n = SET_W / 2; n >= 1; n = n / 2) begin
      for (int i = 0; i < n; i++) begin
        lvl[i] = lvl[2*i] + lvl[2*i+1];
      end
    end
    return lvl[0];
  endfunction

endpackage

/* rtl/attribute_set_logic_unit.sv */
// ---------------------------------------------------------------------------
// Attribute set logic unit
// Set logic and rank tests on two attribute sets, one word per cycle while the output is not stalled.
// ---------------------------------------------------------------------------
//  channel | direction | payload     | handshake
//  in      | input     | in_word_t   | in_valid_i / in_stall_o
//  out     | output    | out_word_t  | out_valid_o / out_stall_i
//
//  A word is taken into the input register, evaluated in one pass of logic
//  and held in the result register.
//  A new word is accepted every cycle while the output is not stalled.
//  Reset empties both registers; payload is not cleared.
//  An output stall holds the result and backs up one word in the input
//  register before the input stalls.
// ---------------------------------------------------------------------------
module attribute_set_logic_unit
  import asl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic      s1_valid_q;
  in_word_t  s1_word_q;
  logic      out_valid_q;
  out_word_t out_word_q;
  out_word_t res_d;

  logic      out_ready;
  logic      s1_ready;

  logic [SET_W-1:0] a, b, diff, upper, low;
  logic [CNT_W-1:0] cnt_a, cnt_b;
  logic             a_lt_b, a_gt_b, join_ok;

  assign out_ready = ~out_valid_q | ~out_stall_i;
  assign s1_ready  = ~s1_valid_q | out_ready;

  always_comb begin
    a      = s1_word_q.set_a & ATTR_MASK;
    b      = s1_word_q.set_b & ATTR_MASK;
    diff   = a ^ b;
    upper  = prefix_or(diff);
    low    = upper & ~(upper << 1);
    cnt_a  = popcount(a);
    cnt_b  = popcount(b);
    a_lt_b = (cnt_a < cnt_b) | ((cnt_a == cnt_b) & (|(b & low)));
    a_gt_b = (cnt_b < cnt_a) | ((cnt_a == cnt_b) & (|(a & low)));
    join_ok = (|diff) & at_most_one(a & upper) & (|(b & upper)) & at_most_one(b & upper);

    res_d = '0;
    case (s1_word_q.action)
      ACT_AND:      res_d.result_set = a & b;
      ACT_OR:       res_d.result_set = a | b;
      ACT_ANDNOT:   res_d.result_set = a & ~b;
      ACT_LESS:     res_d.flag = a_lt_b;
      ACT_GREATER:  res_d.flag = a_gt_b;
      ACT_SUPERSET: res_d.flag = ((a & b) == b);
      ACT_SUBSET:   res_d.flag = ((a & b) == a);
      ACT_JOIN:     res_d.flag = join_ok;
      ACT_EQUAL:    res_d.flag = (a == b);
      default:      res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_word_q <= in_word_i;
    end
    if (out_ready && s1_valid_q) begin
      out_word_q <= res_d;
    end
  end

  assign in_stall_o  = ~s1_ready;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

/* rtl/asl_checker.sv */
// ---------------------------------------------------------------------------
// Attribute set logic unit checker
// Port-level checks on output hold, result form and word count in flight.
// ---------------------------------------------------------------------------
`include "attribute_set_logic_unit_macros.svh"

module asl_checker
  import asl_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  logic [1:0] inflight_q;
  logic [1:0] inflight_d;
  logic       in_take;
  logic       out_take;
  logic       out_wait;
  logic       both_kinds;

  assign in_take    = in_valid_i & ~in_stall_o;
  assign out_take   = out_valid_o & ~out_stall_i;
  assign out_wait   = out_valid_o & out_stall_i;
  assign both_kinds = out_word_o.flag & (|out_word_o.result_set);

  always_comb begin
    inflight_d = inflight_q;
    case ({in_take, out_take})
      2'b10:   inflight_d = inflight_q + 2'd1;
      2'b01:   inflight_d = inflight_q - 2'd1;
      default: inflight_d = inflight_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= 2'd0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  `ASL_ASSERT_NEXT(a_out_hold, out_wait, out_valid_o && $stable(out_word_o), "result moved")
  `ASL_ASSERT_NOW(a_one_kind, out_valid_o, !both_kinds, "set and flag both nonzero")
  `ASL_ASSERT_NOW(a_no_phantom, out_valid_o, inflight_q != 2'd0, "result with no word in flight")
  `ASL_ASSERT_NOW(a_depth, 1'b1, inflight_q != 2'd3, "more words in flight than registers")
  `ASL_ASSERT_NOW(a_stall_full, in_stall_o, inflight_q == 2'd2, "input stalled with room left")

endmodule

bind attribute_set_logic_unit asl_checker u_asl_checker (.*);
